// ===== rtl/core/rmt_pkg.sv =====
`default_nettype none

package rmt_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 9;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0] count_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/rmt_if.sv =====
`default_nettype none

interface rmt_in_if import rmt_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    start_new;

	modport source (output valid, output sample, output start_new, input ready);
	modport sink (input valid, input sample, input start_new, output ready);
endinterface

interface rmt_out_if import rmt_pkg::*; ();
	logic       valid;
	logic       ready;
	sample_t    median_value;
	count_out_t sample_count;
	logic       overflow;

	modport source (output valid, output median_value, output sample_count,
		output overflow, input ready);
	modport sink (input valid, input median_value, input sample_count,
		input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/running_median_tracker_top.sv =====
`default_nettype none

// running median tracker: every accepted request carries a signed 32-bit sample
// and yields exactly one result with the median of all samples of the current
// stream, the number of samples held and an overflow flag. samples are kept in
// ascending order in a row of CAPACITY cells; a request with start_new set
// empties the row before its sample goes in. the insertion is done in the
// cycle the request is accepted (each cell compares its entry with the
// broadcast sample and either keeps it, takes its left neighbor's entry or
// takes the sample), and then, in the select state, the two middle cells are
// picked by index, the median is formed and loaded into the output register
// once it is free. no new request is taken until then; a result that
// is not taken stalls the block in its select cycle. when the row is full
// the sample is dropped, overflow is set and the median of the held samples
// is reported. with more than 511 samples, sample_count shows the low 9 bits.
module running_median_tracker_top import rmt_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rmt_in_if.sink     in_ch,
	rmt_out_if.source  out_ch
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic          en;
		sample_t       sample;
		logic [CW-1:0] fill;
	} ins_t;

	typedef struct packed {
		logic [CW-1:0] lo_idx;
		logic [CW-1:0] hi_idx;
	} sel_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEL
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          out_valid_q;
	sample_t       out_med_q;
	count_out_t    out_cnt_q;
	logic          out_ovf_q;

	logic          accept;
	logic          out_free;
	logic [CW-1:0] eff_cnt;
	logic          full;
	ins_t          ins;
	sel_t          sel;
	sample_t       median;

	sample_t cell_val [CAPACITY];
	logic    cell_gt  [CAPACITY];
	sample_t lo_parts [CAPACITY];
	sample_t hi_parts [CAPACITY];

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// start of a new stream counts as an empty row for this insertion
	assign eff_cnt = in_ch.start_new ? '0 : cnt_q;
	assign full    = (eff_cnt == CW'(CAPACITY));

	assign ins.en     = accept && !full;
	assign ins.sample = in_ch.sample;
	assign ins.fill   = eff_cnt;

	// middle entries of the registered fill; lo only matters for even counts
	assign sel.hi_idx = cnt_q >> 1;
	assign sel.lo_idx = sel.hi_idx - CW'(1);

	// sorted row: cell i, when empty or its entry exceeds the sample, takes cell i-1's entry or else the sample
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		sample_t left_val;
		logic    left_gt;
		if (g == 0) begin : g_first
			assign left_val = '0;
			assign left_gt  = 1'b0;
		end else begin : g_rest
			assign left_val = cell_val[g-1];
			assign left_gt  = cell_gt[g-1];
		end
		rmt_cell #(
			.IDX   (g),
			.CW    (CW),
			.ins_t (ins_t),
			.sel_t (sel_t)
		) u_cell (
			.clk      (clk),
			.ins      (ins),
			.sel      (sel),
			.left_val (left_val),
			.left_gt  (left_gt),
			.val      (cell_val[g]),
			.gt       (cell_gt[g]),
			.lo_part  (lo_parts[g]),
			.hi_part  (hi_parts[g])
		);
	end

	rmt_median #(
		.N  (CAPACITY),
		.CW (CW)
	) u_median (
		.lo_parts (lo_parts),
		.hi_parts (hi_parts),
		.fill     (cnt_q),
		.median   (median)
	);

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result loads, otherwise a taken result empties the register
			if (state_q == ST_SEL && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= full ? eff_cnt : eff_cnt + CW'(1);
						ovf_q   <= full;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					// hold the selection until the output register can take it
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded together with its valid
	always_ff @(posedge clk) begin
		if (state_q == ST_SEL && out_free) begin
			out_med_q <= median;
			out_cnt_q <= COUNT_W'(cnt_q);
			out_ovf_q <= ovf_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.median_value = out_med_q;
	assign out_ch.sample_count = out_cnt_q;
	assign out_ch.overflow     = out_ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/rmt_cell.sv =====
`default_nettype none

module rmt_cell import rmt_pkg::*; #(
	parameter int  IDX = 0,
	parameter int  CW  = 9,
	parameter type ins_t = logic,
	parameter type sel_t = logic
) (
	input  wire logic    clk,
	input  wire ins_t    ins,
	input  wire sel_t    sel,
	input  wire sample_t left_val,
	input  wire logic    left_gt,
	output sample_t      val,
	output logic         gt,
	output sample_t      lo_part,
	output sample_t      hi_part
);

	sample_t val_q;

	// empty slots count as larger than any sample so they take the shifted value or the sample
	assign gt = (CW'(IDX) >= ins.fill) || (val_q > ins.sample);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ins.en && gt) begin
			val_q <= left_gt ? left_val : ins.sample;
		end
	end

	assign lo_part = (CW'(IDX) == sel.lo_idx) ? val_q : '0;
	assign hi_part = (CW'(IDX) == sel.hi_idx) ? val_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/rmt_median.sv =====
`default_nettype none

module rmt_median import rmt_pkg::*; #(
	parameter int N  = 256,
	parameter int CW = 9
) (
	input  wire sample_t       lo_parts [N],
	input  wire sample_t       hi_parts [N],
	input  wire logic [CW-1:0] fill,
	output sample_t            median
);

	sample_t                lo_v;
	sample_t                hi_v;
	logic signed [DATA_W:0] sum;

	// only the addressed cell drives nonzero, so an or-reduce picks it out
	always_comb begin
		lo_v = '0;
		hi_v = '0;
		for (int i = 0; i < N; i++) begin
			lo_v = lo_v | lo_parts[i];
			hi_v = hi_v | hi_parts[i];
		end
	end

	assign sum = {lo_v[DATA_W-1], lo_v} + {hi_v[DATA_W-1], hi_v};

	// arithmetic halving of the 33-bit sum floors toward minus infinity
	assign median = fill[0] ? hi_v : sum[DATA_W:1];

endmodule

`default_nettype wire

// ===== rtl/core/rmt_checker.sv =====
`default_nettype none

module rmt_checker import rmt_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       overflow,
	input wire count_out_t sample_count
);

	// a held result stays until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// one item at a time: no new request right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous item still in work");

	// a dropped sample only happens with a full row
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> sample_count == COUNT_W'(CAPACITY))
		else $error("overflow reported with a row that is not full");

	// an inserted sample leaves at least one entry held
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overflow && CAPACITY < 512 |-> sample_count != '0)
		else $error("result shows an empty row after an insertion");

endmodule

bind running_median_tracker_top rmt_checker #(
	.CAPACITY (CAPACITY)
) u_rmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.overflow     (out_ch.overflow),
	.sample_count (out_ch.sample_count)
);

`default_nettype wire

// ===== tb/running_median_tracker_top_tb.sv =====
`default_nettype none

module running_median_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmt_pkg::*;

	localparam int CAPACITY     = 256;
	localparam int IDLE_MAX     = 11;
	localparam int HOLD_LEN     = 90;
	localparam int STALL_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 4;
	localparam int RANDOM_ITEMS = 600;
	localparam int MAX_REPORTS  = 10;

	localparam sample_t S_MAX = 32'h7fff_ffff;
	localparam sample_t S_MIN = 32'h8000_0000;

	// one request as queued for the driver: payload plus its pacing
	typedef struct {
		sample_t sample;
		logic    start_new;
		int      gap;
		bit      drain;
	} sample_req_t;

	// one result, compared as a whole but reported field by field
	typedef struct packed {
		sample_t    median_value;
		count_out_t sample_count;
		logic       overflow;
	} median_res_t;

	logic clk;
	logic arst_n;

	rmt_in_if  in_if();
	rmt_out_if out_if();

	running_median_tracker_top #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	// requests not yet offered, results predicted but not yet seen
	sample_req_t req_queue[$];
	median_res_t median_queue[$];
	// our own ascending copy of the samples of the current stream
	sample_t     sorted_copy[$];

	sample_req_t nxt_req;
	median_res_t want_res;
	median_res_t got_res;
	int          tx_wait;
	int          rx_wait;
	int          rx_left;
	int          hold_left;
	int          holds_done;
	int          n_in;
	int          n_out;
	int          n_streams;
	int          n_overflow;
	int          mismatches;
	int          idle_cycles;

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// insert into the sorted copy and work out the median it then reports
	function automatic median_res_t predict_median(sample_t v, logic start);
		median_res_t             r;
		int                      pos;
		int                      n;
		logic signed [DATA_W:0]  pair_sum;
		if (start) begin
			sorted_copy.delete();
		end
		r.overflow = 1'b0;
		if (sorted_copy.size() >= CAPACITY) begin
			// full: sample is dropped
			r.overflow = 1'b1;
		end else begin
			// new sample goes after all equal entries
			pos = sorted_copy.size();
			while (pos > 0 && sorted_copy[pos-1] > v) begin
				pos--;
			end
			sorted_copy.insert(pos, v);
		end
		n = sorted_copy.size();
		if (n == 0) begin
			r.median_value = '0;
		end else if (n % 2 == 1) begin
			r.median_value = sorted_copy[n/2];
		end else begin
			// 33-bit sum, dropping the low bit floors toward minus infinity
			pair_sum = $signed({sorted_copy[n/2-1][DATA_W-1], sorted_copy[n/2-1]})
				+ $signed({sorted_copy[n/2][DATA_W-1], sorted_copy[n/2]});
			r.median_value = pair_sum[DATA_W:1];
		end
		r.sample_count = count_out_t'(n);
		return r;
	endfunction

	// queue a request; every fourth stretch of 64 requests runs with no gaps
	task automatic add_req(input sample_t s, input logic st, input bit drain);
		sample_req_t r;
		r.sample    = s;
		r.start_new = st;
		r.drain     = drain;
		r.gap       = ((req_queue.size() / 64) % 4 == 2) ? 0 : $urandom_range(IDLE_MAX);
		req_queue.push_back(r);
	endtask

	task automatic note_failure(input string what, input median_res_t want,
		input median_res_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t %s: expected median %0d count %0d overflow %0b",
				$realtime, what, $signed(want.median_value), want.sample_count,
				want.overflow);
			$display("%0t %s: got median %0d count %0d overflow %0b",
				$realtime, what, $signed(got.median_value), got.sample_count,
				got.overflow);
		end
	endtask

	// driver: offers queued requests, predicts each one on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid     <= 1'b0;
			in_if.sample    <= '0;
			in_if.start_new <= 1'b0;
			tx_wait         <= 0;
			n_in            <= 0;
			n_streams       <= 0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				median_queue.push_back(predict_median(in_if.sample, in_if.start_new));
				n_in <= n_in + 1;
				if (in_if.start_new) begin
					n_streams <= n_streams + 1;
				end
			end
			// bus is free for the next request
			if (!in_if.valid || in_if.ready) begin
				if (req_queue.size() == 0) begin
					in_if.valid <= 1'b0;
				end else if (tx_wait < req_queue[0].gap && hold_left == 0) begin
					// idle gap, skipped while the receiver holds off so the block fills
					tx_wait     <= tx_wait + 1;
					in_if.valid <= 1'b0;
				end else if (req_queue[0].drain && n_out != n_in + (in_if.valid ? 1 : 0)) begin
					// pause until every outstanding result has come back
					in_if.valid <= 1'b0;
				end else begin
					nxt_req = req_queue.pop_front();
					in_if.valid     <= 1'b1;
					in_if.sample    <= nxt_req.sample;
					in_if.start_new <= nxt_req.start_new;
					tx_wait         <= 0;
				end
			end
		end
	end

	// long receiver hold-offs, once early and once late in the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && n_in == 40) || (holds_done == 1 && n_in == 420)) begin
			hold_left  <= HOLD_LEN;
			holds_done <= holds_done + 1;
		end
	end

	// monitor: takes results with random waits, checks against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			rx_wait      <= 0;
			n_out        <= 0;
			n_overflow   <= 0;
		end else begin
			rx_left = rx_wait;
			if (out_if.valid && out_if.ready) begin
				got_res = '{out_if.median_value, out_if.sample_count, out_if.overflow};
				if (n_out >= n_in) begin
					// nothing was accepted that this result could belong to
					note_failure("unexpected result", '0, got_res);
				end else begin
					want_res = median_queue.pop_front();
					n_out <= n_out + 1;
					if (got_res !== want_res) begin
						note_failure("mismatch", want_res, got_res);
					end
					if (want_res.overflow) begin
						n_overflow <= n_overflow + 1;
					end
				end
				// every fourth stretch of 80 results is taken with no waits
				rx_left = ((n_out / 80) % 4 == 1) ? 0 : $urandom_range(IDLE_MAX);
			end else if (rx_left != 0) begin
				rx_left--;
			end
			rx_wait      <= rx_left;
			out_if.ready <= (rx_left == 0) && (hold_left == 0);
		end
	end

	// watchdog: cycles in which neither side moves a request or a result
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t timeout: no handshake for %0d cycles", $realtime, STALL_LIMIT);
			$display("running_median_tracker_top_tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int      idx;
		int      len;
		int      k;
		bit      filling;
		bit      full_done;
		logic    st;
		sample_t s;

		in_if.valid     = 1'b0;
		in_if.sample    = '0;
		in_if.start_new = 1'b0;
		out_if.ready    = 1'b0;
		arst_n          = 1'b0;
		idle_cycles     = 0;
		mismatches      = 0;

		// directed: extremes, 33-bit sums, floor on negative halves, equal samples
		add_req(sample_t'(0), 1'b1, 1'b0);
		add_req(S_MIN, 1'b0, 1'b0);
		add_req(S_MAX, 1'b0, 1'b0);
		add_req(S_MAX, 1'b0, 1'b0);
		add_req(S_MAX, 1'b1, 1'b0);
		add_req(S_MAX, 1'b0, 1'b0);
		add_req(S_MIN, 1'b1, 1'b0);
		add_req(S_MIN, 1'b0, 1'b0);
		add_req(sample_t'(-1), 1'b1, 1'b1);
		add_req(sample_t'(-2), 1'b0, 1'b0);
		add_req(sample_t'(-3), 1'b1, 1'b0);
		add_req(sample_t'(0), 1'b0, 1'b0);
		add_req(sample_t'(5), 1'b0, 1'b0);
		add_req(sample_t'(5), 1'b0, 1'b0);
		add_req(sample_t'(5), 1'b0, 1'b0);
		add_req(sample_t'(7), 1'b1, 1'b0);
		add_req(sample_t'(-7), 1'b0, 1'b0);
		add_req(sample_t'(32'h5555_5555), 1'b0, 1'b0);
		add_req(sample_t'(32'haaaa_aaaa), 1'b0, 1'b0);
		add_req(S_MIN, 1'b0, 1'b0);
		add_req(S_MAX, 1'b0, 1'b0);

		// random streams, mostly short; one is filled past capacity and the
		// next stream then starts on a full store
		idx       = 0;
		full_done = 1'b0;
		while (idx < RANDOM_ITEMS) begin
			filling = 1'b0;
			if (!full_done && idx >= 150) begin
				len       = CAPACITY + 6;
				filling   = 1'b1;
				full_done = 1'b1;
			end else if ($urandom_range(7) == 0) begin
				len = $urandom_range(60, 20);
			end else begin
				len = $urandom_range(12, 1);
			end
			for (k = 0; k < len; k++) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: s = sample_t'($urandom);
					5, 6:          s = sample_t'(int'($urandom_range(16)) - 8);
					7:             s = $urandom_range(1) ? S_MAX : S_MIN;
					default:       s = sample_t'(int'($urandom_range(2000)) - 1000);
				endcase
				// stray start flags break a stream now and then
				st = (k == 0) || (!filling && $urandom_range(24) == 0);
				add_req(s, st, $urandom_range(39) == 0);
				idx++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// all requests taken and every prediction answered
		@(negedge clk);
		while (req_queue.size() != 0 || in_if.valid || n_out != n_in) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (median_queue.size() != 0) begin
			$display("%0t %0d predicted results never arrived", $realtime, median_queue.size());
			mismatches += median_queue.size();
		end

		$display("covered %0d requests in %0d streams, %0d dropped on a full store",
			n_in, n_streams, n_overflow);
		$display("with %0d long receiver hold-offs and %0d failures", holds_done, mismatches);
		if (mismatches == 0) begin
			$display("running_median_tracker_top_tb: PASS");
		end else begin
			$display("running_median_tracker_top_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/rmt_pkg.sv
rtl/core/rmt_if.sv
rtl/core/rmt_cell.sv
rtl/core/rmt_median.sv
rtl/core/running_median_tracker_top.sv
rtl/core/rmt_checker.sv
tb/running_median_tracker_top_tb.sv
